FILE: hdl/ecd_pkg.sv
// Shared types, constants and the month length table for the epoch to
// calendar date unit. No dependencies; every other file imports this one.
package ecd_pkg;

  // Calendar and clock constants
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
  localparam logic [15:0] DAYS_PER_WEEK = 16'd7;
  localparam logic [11:0] FIRST_YEAR    = 12'd1970;

  // Residues of the first year for the leap counters
  localparam logic [1:0] FIRST_Y4   = 2'd2;
  localparam logic [6:0] FIRST_Y100 = 7'd70;
  localparam logic [8:0] FIRST_Y400 = 9'd370;
  localparam logic [6:0] LAST_Y100  = 7'd99;
  localparam logic [8:0] LAST_Y400  = 9'd399;

  localparam logic [8:0] DAYS_LEAP   = 9'd366;
  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [3:0] LAST_MONTH  = 4'd11;

  // Reciprocals for division by constants (exact over the operand ranges)
  // ms / 1000          = (ms * MS_RECIP) >> 38
  // (t >> 7) / 675     = ((t >> 7) * DAY_RECIP) >> 35
  // (sod >> 4) / 225   = ((sod >> 4) * HOUR_RECIP) >> 21
  // w / 7              = (w * WEEK_RECIP) >> 19
  // (rem >> 2) / 15    = ((rem >> 2) * MIN_RECIP) >> 14
  localparam logic [28:0] MS_RECIP   = 29'd274877907;
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [16:0] WEEK_RECIP = 17'd74899;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  localparam int QUEUE_DEPTH = 2;

  // Time of day split, weekday and day count, handed from front to back
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [15:0] days;
  } ecd_front_item_t;

  // One finished result item
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
  } ecd_result_t;

  // Days in month m (0 is January)
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1:                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/ecd_front.sv
// Front end: accepts an item, forms local seconds and splits them into
// time of day, weekday and day count. Depends on ecd_pkg.
module ecd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [31:0]             in_server_epoch,
  input  logic [31:0]             in_elapsed_ms,
  input  logic [17:0]             time_offset,
  output logic                    push,
  output ecd_pkg::ecd_front_item_t push_item,
  input  logic                    push_ready
);
  import ecd_pkg::*;

  localparam logic [3:0] FS_IDLE = 4'd0;
  localparam logic [3:0] FS_MS   = 4'd1;
  localparam logic [3:0] FS_SUM  = 4'd2;
  localparam logic [3:0] FS_DAYS = 4'd3;
  localparam logic [3:0] FS_SOD  = 4'd4;
  localparam logic [3:0] FS_HOUR = 4'd5;
  localparam logic [3:0] FS_REM  = 4'd6;
  localparam logic [3:0] FS_MIN  = 4'd7;
  localparam logic [3:0] FS_SEC  = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] epoch_r, ms_r, t_r;
  logic [17:0] off_r;
  logic [22:0] qms_r;
  logic [15:0] days_r;
  logic [16:0] sod_r;
  logic [4:0]  hour_r;
  logic [13:0] wq_r;
  logic [11:0] rem_r;
  logic [2:0]  weekday_r;
  logic [5:0]  min_r;

  logic [60:0] ms_prod;
  logic [31:0] t_sum;
  logic [50:0] day_prod;
  logic [31:0] sod_full;
  logic [26:0] hour_prod;
  logic [15:0] wk_sum;
  logic [32:0] wk_prod;
  logic [16:0] rem_full;
  logic [15:0] wk_full;
  logic [20:0] min_prod;
  logic [11:0] sec_full;

  // Arithmetic per step, at most two multiplies each
  assign ms_prod   = {29'd0, ms_r} * {32'd0, MS_RECIP};
  assign t_sum     = epoch_r + {9'd0, qms_r} + {{14{off_r[17]}}, off_r};
  assign day_prod  = {26'd0, t_r[31:7]} * {25'd0, DAY_RECIP};
  assign sod_full  = t_r - ({16'd0, days_r} * SECS_PER_DAY);
  assign hour_prod = {14'd0, sod_r[16:4]} * {13'd0, HOUR_RECIP};
  assign wk_sum    = days_r + EPOCH_WEEKDAY;
  assign wk_prod   = {17'd0, wk_sum} * {16'd0, WEEK_RECIP};
  assign rem_full  = sod_r - ({12'd0, hour_r} * SECS_PER_HOUR);
  assign wk_full   = wk_sum - ({2'd0, wq_r} * DAYS_PER_WEEK);
  assign min_prod  = {11'd0, rem_r[11:2]} * {10'd0, MIN_RECIP};
  assign sec_full  = rem_r - ({6'd0, min_r} * SECS_PER_MIN);

  assign in_ready = (state_r == FS_IDLE);
  assign push     = (state_r == FS_SEC);

  assign push_item.hour    = hour_r;
  assign push_item.minute  = min_r;
  assign push_item.second  = sec_full[5:0];
  assign push_item.weekday = weekday_r;
  assign push_item.days    = days_r;

  // Step sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: if (in_valid) state_nxt = FS_MS;
      FS_MS:   state_nxt = FS_SUM;
      FS_SUM:  state_nxt = FS_DAYS;
      FS_DAYS: state_nxt = FS_SOD;
      FS_SOD:  state_nxt = FS_HOUR;
      FS_HOUR: state_nxt = FS_REM;
      FS_REM:  state_nxt = FS_MIN;
      FS_MIN:  state_nxt = FS_SEC;
      FS_SEC:  if (push_ready) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers, written in the step that produces them
  always_ff @(posedge clk) begin
    unique case (state_r)
      FS_IDLE: begin
        if (in_valid) begin
          epoch_r <= in_server_epoch;
          ms_r    <= in_elapsed_ms;
          off_r   <= time_offset;
        end
      end
      FS_MS:   qms_r  <= ms_prod[60:38];
      FS_SUM:  t_r    <= t_sum;
      FS_DAYS: days_r <= day_prod[50:35];
      FS_SOD:  sod_r  <= sod_full[16:0];
      FS_HOUR: begin
        hour_r <= hour_prod[25:21];
        wq_r   <= wk_prod[32:19];
      end
      FS_REM: begin
        rem_r     <= rem_full[11:0];
        weekday_r <= wk_full[2:0];
      end
      FS_MIN:  min_r <= min_prod[19:14];
      default: ;
    endcase
  end

endmodule

FILE: hdl/ecd_queue.sv
// Two-entry queue between front and back end.
// Depends on ecd_pkg for the item type and depth.
module ecd_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_valid,
  output logic                     wr_ready,
  input  ecd_pkg::ecd_front_item_t wr_item,
  output logic                     rd_valid,
  input  logic                     rd_ready,
  output ecd_pkg::ecd_front_item_t rd_item
);
  import ecd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW:0] FULL_COUNT = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  ecd_front_item_t      mem_r [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [PW:0]          count_r;
  logic                 do_wr, do_rd;

  assign wr_ready = (count_r != FULL_COUNT);
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule

FILE: hdl/ecd_back.sv
// Back end: walks years and months over the day count, then holds the
// finished item in the output register. Depends on ecd_pkg.
module ecd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_valid,
  output logic                     rd_ready,
  input  ecd_pkg::ecd_front_item_t rd_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ecd_pkg::ecd_result_t     out_result
);
  import ecd_pkg::*;

  localparam logic [1:0] BS_IDLE  = 2'd0;
  localparam logic [1:0] BS_YEAR  = 2'd1;
  localparam logic [1:0] BS_MONTH = 2'd2;
  localparam logic [1:0] BS_DONE  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  ecd_front_item_t tod_r;
  logic [15:0]     days_r;
  logic [11:0]     year_r;
  logic [1:0]      y4_r;
  logic [6:0]      y100_r;
  logic [8:0]      y400_r;
  logic [3:0]      mon_r;
  logic            out_valid_r;
  ecd_result_t     out_r;

  logic            leap;
  logic [8:0]      ylen;
  logic [4:0]      mlen;
  logic            year_fits, month_fits, load_out;

  // Leap rule from the residue counters
  assign leap       = (y4_r == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen       = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen       = month_len(mon_r, leap);
  assign year_fits  = (days_r < {7'd0, ylen});
  assign month_fits = (days_r < {11'd0, mlen});
  assign load_out   = (state_r == BS_DONE) && (!out_valid_r || out_ready);

  assign rd_ready   = (state_r == BS_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // Walk sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE:  if (rd_valid) state_nxt = BS_YEAR;
      BS_YEAR:  if (year_fits) state_nxt = BS_MONTH;
      BS_MONTH: if (month_fits || (mon_r == LAST_MONTH)) state_nxt = BS_DONE;
      BS_DONE:  if (load_out) state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      BS_IDLE: begin
        if (rd_valid) begin
          tod_r  <= rd_item;
          days_r <= rd_item.days;
          year_r <= FIRST_YEAR;
          y4_r   <= FIRST_Y4;
          y100_r <= FIRST_Y100;
          y400_r <= FIRST_Y400;
          mon_r  <= '0;
        end
      end
      BS_YEAR: begin
        if (!year_fits) begin
          days_r <= days_r - {7'd0, ylen};
          year_r <= year_r + 12'd1;
          y4_r   <= y4_r + 2'd1;
          y100_r <= (y100_r == LAST_Y100) ? 7'd0 : y100_r + 7'd1;
          y400_r <= (y400_r == LAST_Y400) ? 9'd0 : y400_r + 9'd1;
        end
      end
      BS_MONTH: begin
        if (!month_fits) begin
          days_r <= days_r - {11'd0, mlen};
          if (mon_r != LAST_MONTH) mon_r <= mon_r + 4'd1;
        end
      end
      BS_DONE: begin
        if (load_out) begin
          out_r.hour         <= tod_r.hour;
          out_r.minute       <= tod_r.minute;
          out_r.second       <= tod_r.second;
          out_r.weekday      <= tod_r.weekday;
          out_r.day_of_month <= days_r[4:0] + 5'd1;
          out_r.month        <= mon_r + 4'd1;
          out_r.year         <= year_r;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/epoch_to_calendar_date_unit.sv
// Top level of the epoch to calendar date unit: offset register, front end,
// queue and back end. Depends on ecd_pkg, ecd_front, ecd_queue, ecd_back.
//
// Usage:
//  - cfg channel writes the signed 18-bit time zone offset in seconds; it is
//    always ready and is meant to be written while the unit is idle.
//  - in channel takes server_epoch and elapsed_ms; one result item is
//    produced for every input item, in order, on the out channel.
//  - The front end steps through MS, SUM, DAYS, SOD, HOUR, REM, MIN and SEC
//    (a chain of reciprocal multiplies for /1000, /86400, /3600, /60 and
//    /7), and in_ready stays low from each accept until it is back in idle.
//  - The back end walks one year per cycle from 1970 and one month per
//    cycle. Sustained rate is set by the slower of the front end's steps
//    and the back-end walk.
//  - A two-entry queue sits between front and back, and the output register
//    frees the back end once a result is loaded into it, so the front end
//    keeps accepting while a result waits on a stalled receiver.
//  - Reset (rst_n low, synchronous) clears the offset to 0, empties the
//    queue and drops out_valid.
module epoch_to_calendar_date_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [17:0] cfg_time_offset,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_server_epoch,
  input  logic [31:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month,
  output logic [11:0] out_year
);
  import ecd_pkg::*;

  logic [17:0]     offset_r;
  logic            push, push_ready;
  ecd_front_item_t push_item;
  logic            q_valid, q_ready;
  ecd_front_item_t q_item;
  ecd_result_t     result;

  // Offset register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_valid) begin
      offset_r <= cfg_time_offset;
    end
  end

  ecd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_server_epoch (in_server_epoch),
    .in_elapsed_ms   (in_elapsed_ms),
    .time_offset     (offset_r),
    .push            (push),
    .push_item       (push_item),
    .push_ready      (push_ready)
  );

  ecd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  ecd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_valid   (q_valid),
    .rd_ready   (q_ready),
    .rd_item    (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign out_hour         = result.hour;
  assign out_minute       = result.minute;
  assign out_second       = result.second;
  assign out_weekday      = result.weekday;
  assign out_day_of_month = result.day_of_month;
  assign out_month        = result.month;
  assign out_year         = result.year;

  // Front end goes busy right after taking an item
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front end ready right after accepting an item");

  // A stalled result stays up and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(result)))
    else $error("result item dropped or changed while stalled");

  // The front end's pushed item waits unchanged while the queue is full
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !push_ready) |=> (push && $stable(push_item)))
    else $error("front end dropped or changed a queued item");

  // A shown result is a legal time, weekday and month
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_month >= 4'd1) && (out_month <= 4'd12) &&
                   (out_hour <= 5'd23) && (out_minute <= 6'd59) &&
                   (out_second <= 6'd59) && (out_weekday <= 3'd6)))
    else $error("result item out of range");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for epoch_to_calendar_date_unit: timestamp items in,
// calendar date items out, checked against an in-bench calendar predictor.
// Depends on ecd_pkg and the RTL under hdl/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecd_pkg::*;

  localparam int RANDOM_PER_PHASE = 150;
  localparam int STALL_LIMIT      = 3000;
  localparam int DRAIN_CYCLES     = 300;

  // One timestamp read: server seconds plus milliseconds since the read
  typedef struct packed {
    logic [31:0] epoch;
    logic [31:0] ms;
  } clock_read_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [17:0] cfg_time_offset = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_server_epoch = '0;
  logic [31:0] in_elapsed_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month;
  logic [11:0] out_year;

  clock_read_t pending_reads[$];
  ecd_result_t expected_dates[$];
  logic [17:0] zone_offset = '0;
  int          mismatches = 0;

  epoch_to_calendar_date_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_time_offset  (cfg_time_offset),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_server_epoch  (in_server_epoch),
    .in_elapsed_ms    (in_elapsed_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gregorian leap rule
  function automatic bit is_leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // m counts from 0 (January)
  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      1:          return is_leap_year(y) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  // Seconds from 1970-01-01 to Jan 1 of year y
  function automatic logic [31:0] year_start(int unsigned y);
    logic [31:0] secs;
    secs = '0;
    for (int unsigned yy = 1970; yy < y; yy++)
      secs += (is_leap_year(yy) ? 32'd366 : 32'd365) * 32'd86400;
    return secs;
  endfunction

  // Local date and time for one read under the given zone offset
  function automatic ecd_result_t calendar_of(logic [31:0] epoch, logic [31:0] ms,
                                               logic [17:0] offset);
    ecd_result_t r;
    logic [31:0] t;
    logic [31:0] days;
    int unsigned yr, mon, span;
    t = {{14{offset[17]}}, offset} + epoch + ms / 32'd1000;  // wraps mod 2^32
    r.hour    = 5'((t % 32'd86400) / 32'd3600);
    r.minute  = 6'((t % 32'd3600) / 32'd60);
    r.second  = 6'(t % 32'd60);
    days      = t / 32'd86400;
    r.weekday = 3'((days + 32'd4) % 32'd7);  // 1970-01-01 was a Thursday
    // walk whole years, then whole months
    yr = 1970;
    span = is_leap_year(yr) ? 366 : 365;
    while (days >= span) begin
      days -= span;
      yr++;
      span = is_leap_year(yr) ? 366 : 365;
    end
    mon = 0;
    span = days_in_month(mon, yr);
    while (mon < 11 && days >= span) begin
      days -= span;
      mon++;
      span = days_in_month(mon, yr);
    end
    r.day_of_month = 5'(days + 32'd1);
    r.month        = 4'(mon + 1);
    r.year         = 12'(yr);
    return r;
  endfunction

  // Random read, biased toward month and year turns, wrap and ms boundaries
  function automatic clock_read_t random_read();
    clock_read_t r;
    int unsigned yr, day, sec;
    int unsigned turn_days[6] = '{0, 58, 59, 60, 364, 365};
    r.epoch = $urandom();
    r.ms    = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5: r.ms = $urandom_range(0, 999999);
      6, 7: begin
        yr  = $urandom_range(1970, 2105);
        day = turn_days[$urandom_range(0, 5)];
        case ($urandom_range(0, 2))
          0:       sec = 0;
          1:       sec = 86399;
          default: sec = $urandom_range(0, 86399);
        endcase
        r.epoch = year_start(yr) + day * 86400 + sec;
        r.ms    = $urandom_range(0, 2999);
      end
      8: r.epoch = ($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF) ^ $urandom_range(0, 200000);
      default: r.ms = $urandom_range(0, 4294966) * 1000 + ($urandom_range(0, 1) ? 999 : 0);
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Block until every queued read is sent and every result has come back;
  // sampled mid-cycle so the edge's updates have all landed
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reads.size() != 0 || in_valid || expected_dates.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_zone(logic [17:0] value);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_time_offset <= value;
    do @(posedge clk);
    while (!cfg_ready);
    zone_offset = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_randoms();
    repeat (RANDOM_PER_PHASE) pending_reads.push_back(random_read());
  endtask

  // Stimulus: reset, directed reads, then one random phase per zone offset
  initial begin
    int zone_steps[6];
    zone_steps = '{86400, -86400, 131071, -131072, -3600, 0};
    zone_steps[5] = int'($urandom_range(0, 172800)) - 86400;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset offset of zero; field extremes and calendar corners
    pending_reads.push_back('{32'd0, 32'd0});                  // the epoch itself
    pending_reads.push_back('{32'hFFFF_FFFF, 32'd0});          // 2106-02-07 06:28:15, largest epoch
    pending_reads.push_back('{32'd0, 32'hFFFF_FFFF});          // largest elapsed time
    pending_reads.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});  // sum wraps past 2^32
    pending_reads.push_back('{32'd0, 32'd999});                // ms rounds down
    pending_reads.push_back('{32'd0, 32'd1000});
    pending_reads.push_back('{32'd59, 32'd1000});              // minute carry
    pending_reads.push_back('{32'd86399, 32'd0});              // day carry
    pending_reads.push_back('{32'd86400, 32'd0});
    pending_reads.push_back('{32'd68169600, 32'd0});           // 1972-02-29
    pending_reads.push_back('{32'd951782400, 32'd0});          // 2000-02-29, century leap
    pending_reads.push_back('{32'd951868800, 32'd0});          // 2000-03-01
    pending_reads.push_back('{32'd4107456000, 32'd0});         // 2100-02-28
    pending_reads.push_back('{32'd4107542399, 32'd0});
    pending_reads.push_back('{32'd4107542400, 32'd0});         // 2100 is not leap
    pending_reads.push_back('{32'd946684799, 32'd0});          // end of 1999
    pending_reads.push_back('{32'd1483228799, 32'd0});         // end of leap year 2016
    pending_reads.push_back('{32'd1483228800, 32'd0});
    pending_reads.push_back('{32'hAAAA_AAAA, 32'h5555_5555});
    pending_reads.push_back('{32'h5555_5555, 32'hAAAA_AAAA});
    queue_randoms();

    // each zone offset, extremes included
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_zone(zone_steps[p][17:0]);
      @(negedge clk);
      pending_reads.push_back('{32'd0, 32'd0});                  // offset may wrap below 1970
      pending_reads.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
      queue_randoms();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_dates.size() != 0) begin
      $error("%0d predicted results never arrived", expected_dates.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Sender: bursts of items with random gaps; predicts on each accept
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    clock_read_t nxt;
    if (in_valid && in_ready)
      expected_dates.push_back(calendar_of(in_server_epoch, in_elapsed_ms, zone_offset));
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reads.size() != 0) begin
        nxt = pending_reads.pop_front();
        in_valid        <= 1'b1;
        in_server_epoch <= nxt.epoch;
        in_elapsed_ms   <= nxt.ms;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 12);
          case ($urandom_range(0, 2))
            0:       gap_left <= 0;
            1:       gap_left <= $urandom_range(1, 20);
            default: gap_left <= $urandom_range(21, 160);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall style is redrawn whenever the mode timer wraps
  int unsigned stall_left = 0;
  int unsigned mode_timer = 0;
  int unsigned ready_mode = 0;

  always @(posedge clk) begin
    if (mode_timer == 700) begin
      mode_timer <= 0;
      ready_mode <= $urandom_range(0, 2);
    end else begin
      mode_timer <= mode_timer + 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (ready_mode == 1 && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else if (ready_mode == 2 && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(10, 40);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin
    ecd_result_t want;
    if (out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("result item with no prediction pending");
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        check_field("hour", want.hour, out_hour);
        check_field("minute", want.minute, out_minute);
        check_field("second", want.second, out_second);
        check_field("weekday", want.weekday, out_weekday);
        check_field("day_of_month", want.day_of_month, out_day_of_month);
        check_field("month", want.month, out_month);
        check_field("year", want.year, out_year);
      end
    end
  end

  // Watchdog: too long without any handshake on any channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no handshake for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
